// ===== rtl/core/batch_weight_update_rprop_quickprop_assert.svh =====
// Assertion macros shared by the weight update RTL
`ifndef BATCH_WEIGHT_UPDATE_RPROP_QUICKPROP_ASSERT_SVH
`define BATCH_WEIGHT_UPDATE_RPROP_QUICKPROP_ASSERT_SVH

// condition in the same cycle implies consequence in the same cycle
`define BWU_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define BWU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/bwu_pkg.sv =====
// Constants, types and helpers for the batch weight update pipeline
package bwu_pkg;

   // fixed point format and tuning constants
   localparam int FRAC_BITS = 16;
   localparam logic signed [31:0] RPROP_STEP_MIN   = 32'sd0;
   localparam logic signed [31:0] RPROP_STEP_FLOOR = 32'sd0;
   localparam logic signed [31:0] QP_DECAY         = 32'sd0;
   localparam logic signed [31:0] QP_MIN_STEP      = 32'sd0;
   localparam logic signed [31:0] QP_MIN_STEP_NEG  = -QP_MIN_STEP;
   localparam logic [31:0]        FX_ONE           = 32'(64'd1 << FRAC_BITS);

   // quotient bits kept from the quadratic divide, ratio bits, change width
   localparam int QB = 64 - FRAC_BITS;
   localparam int RB = FRAC_BITS;
   localparam int CW = QB + 2;

   // mode codes
   localparam logic [1:0] MODE_PLAIN = 2'd0;
   localparam logic [1:0] MODE_RPROP = 2'd1;
   localparam logic [1:0] MODE_QPROP = 2'd2;

   // register indexes
   localparam logic [2:0] REG_MODE       = 3'd0;
   localparam logic [2:0] REG_BATCH_RATE = 3'd1;
   localparam logic [2:0] REG_WEIGHT_MIN = 3'd2;
   localparam logic [2:0] REG_WEIGHT_MAX = 3'd3;
   localparam logic [2:0] REG_GROW       = 3'd4;
   localparam logic [2:0] REG_SHRINK     = 3'd5;
   localparam logic [2:0] REG_CEILING    = 3'd6;
   localparam logic [2:0] REG_QP_MU      = 3'd7;

   // register reset values
   localparam logic [30:0] GROW_RESET    = 31'd78643;
   localparam logic [30:0] SHRINK_RESET  = 31'd32768;
   localparam logic [30:0] CEILING_RESET = 31'd3276800;

   // stage after the decay term
   typedef struct packed {
      logic signed [31:0] w;
      logic signed [31:0] step;
      logic signed [31:0] prev;
      logic signed [31:0] slope;
      logic signed [31:0] s;
   } s1_type;

   // stage after the multipliers
   typedef struct packed {
      logic signed [31:0] w;
      logic signed [31:0] step;
      logic signed [31:0] prev;
      logic signed [31:0] slope;
      logic signed [31:0] s;
      logic               same;
      logic signed [63:0] plain_prod;
      logic signed [63:0] lin_prod;
      logic signed [63:0] mu_prod;
      logic signed [63:0] num;
      logic signed [63:0] rp_prod;
   } s2_type;

   // divider stage contents
   typedef struct packed {
      logic signed [31:0] w;
      logic signed [31:0] step;
      logic signed [31:0] prev;
      logic signed [31:0] s;
      logic signed [QB-1:0] lin;
      logic signed [QB-1:0] mustep;
      logic               q_neg;
      logic               ovf;
      logic               dz;
      logic [32:0]        r;
      logic [32:0]        den_abs;
      logic [QB-1:0]      num_lo;
      logic [QB-1:0]      q;
      logic [31:0]        rr;
      logic [31:0]        rden;
      logic [RB-1:0]      rq;
      logic signed [31:0] w_plain;
      logic signed [31:0] step_plain;
      logic signed [31:0] w_rp;
      logic signed [31:0] step_rp;
      logic signed [31:0] prev_rp;
   } div_type;

   // stage after the quotient is signed and the ratio compare value formed
   typedef struct packed {
      logic signed [31:0] w;
      logic signed [31:0] step;
      logic signed [31:0] prev;
      logic signed [31:0] s;
      logic signed [QB-1:0] lin;
      logic signed [QB-1:0] mustep;
      logic signed [CW-1:0] quad;
      logic signed [31:0] cmp;
      logic signed [31:0] w_plain;
      logic signed [31:0] step_plain;
      logic signed [31:0] w_rp;
      logic signed [31:0] step_rp;
      logic signed [31:0] prev_rp;
   } p1_type;

   // stage after the QuickProp change
   typedef struct packed {
      logic signed [31:0] w;
      logic signed [31:0] prev;
      logic signed [31:0] s;
      logic signed [31:0] step_q;
      logic signed [31:0] w_plain;
      logic signed [31:0] step_plain;
      logic signed [31:0] w_rp;
      logic signed [31:0] step_rp;
      logic signed [31:0] prev_rp;
   } p2_type;

   // saturate to the signed 32 bit range
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [31:0] res;
      if (x > 64'sd2147483647) begin
         res = 32'sh7FFFFFFF;
      end else if (x < -64'sd2147483648) begin
         res = 32'sh80000000;
      end else begin
         res = x[31:0];
      end
      return res;
   endfunction

endpackage

// ===== rtl/core/batch_weight_update_rprop_quickprop.sv =====
// Batch weight update pipeline: plain step, iRprop- and QuickProp in fixed point
//
//  channel | direction | handshake            | beat contents
//  req     | in        | req_tvalid/req_tready | weight, step, prev slope, slope
//  rsp     | out       | rsp_tvalid/rsp_tready | weight, step, prev slope
//  csr     | in        | csr_we                | register index and value
//
// One beat enters per cycle while rsp is not stalled; the restoring divider for the
// QuickProp quotient, one bit per stage, makes up most of the pipeline.
// Reset clears the valid bits and the registers to their defaults.
// A stall on rsp freezes the whole pipeline, so req_tready drops with it.
`include "batch_weight_update_rprop_quickprop_assert.svh"
module batch_weight_update_rprop_quickprop (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // weight_in, step_in, prev_slope_in, slope_in (32 bits each, lowest first)
   input  logic [127:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // weight_out, step_out, prev_slope_out (32 bits each, lowest first)
   output logic [95:0]  rsp_tdata,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [31:0]  csr_wdata
);
   import bwu_pkg::*;

   // configuration registers
   logic [1:0]         mode_ff;
   logic signed [31:0] rate_ff;
   logic signed [31:0] wmin_ff;
   logic signed [31:0] wmax_ff;
   logic [30:0]        grow_ff;
   logic [30:0]        shrink_ff;
   logic [30:0]        ceil_ff;
   logic [30:0]        mu_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_PLAIN;
         rate_ff   <= '0;
         wmin_ff   <= '0;
         wmax_ff   <= '0;
         grow_ff   <= GROW_RESET;
         shrink_ff <= SHRINK_RESET;
         ceil_ff   <= CEILING_RESET;
         mu_ff     <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_MODE:       mode_ff   <= csr_wdata[1:0];
            REG_BATCH_RATE: rate_ff   <= csr_wdata;
            REG_WEIGHT_MIN: wmin_ff   <= csr_wdata;
            REG_WEIGHT_MAX: wmax_ff   <= csr_wdata;
            REG_GROW:       grow_ff   <= csr_wdata[30:0];
            REG_SHRINK:     shrink_ff <= csr_wdata[30:0];
            REG_CEILING:    ceil_ff   <= csr_wdata[30:0];
            REG_QP_MU:      mu_ff     <= csr_wdata[30:0];
         endcase
      end
   end

   // pipeline registers
   logic    en;
   s1_type  s1_ff, s1_in;
   logic    s1_v_ff;
   s2_type  s2_ff, s2_in;
   logic    s2_v_ff;
   div_type div_ff [0:QB];
   div_type div0_in;
   logic    div_v_ff [0:QB];
   p1_type  p1_ff, p1_in;
   logic    p1_v_ff;
   p2_type  p2_ff, p2_in;
   logic    p2_v_ff;
   logic [95:0] p3_ff, p3_in;
   logic    p3_v_ff;

   // advance everything when the output slot is free or being taken
   assign en         = !p3_v_ff || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = p3_v_ff;
   assign rsp_tdata  = p3_ff;

   // stage 1: unpack and add the decay term
   always_comb begin
      logic signed [63:0] dec;
      dec = (64'(QP_DECAY) * 64'($signed(req_tdata[31:0]))) >>> FRAC_BITS;
      s1_in.w     = req_tdata[31:0];
      s1_in.step  = req_tdata[63:32];
      s1_in.prev  = req_tdata[95:64];
      s1_in.slope = req_tdata[127:96];
      s1_in.s     = sat32(64'($signed(req_tdata[127:96])) + dec);
   end

   // stage 2: all products
   always_comb begin
      logic signed [31:0] ps;
      logic signed [31:0] fac;
      ps = (s1_ff.step < RPROP_STEP_FLOOR) ? RPROP_STEP_FLOOR : s1_ff.step;
      s2_in.same = (!s1_ff.prev[31] && !s1_ff.slope[31]) ||
                   (s1_ff.prev <= 0 && s1_ff.slope <= 0);
      fac = s2_in.same ? $signed({1'b0, grow_ff}) : $signed({1'b0, shrink_ff});
      s2_in.w          = s1_ff.w;
      s2_in.step       = s1_ff.step;
      s2_in.prev       = s1_ff.prev;
      s2_in.slope      = s1_ff.slope;
      s2_in.s          = s1_ff.s;
      s2_in.plain_prod = 64'(s1_ff.slope) * 64'(rate_ff);
      s2_in.lin_prod   = 64'(rate_ff) * 64'(s1_ff.s);
      s2_in.mu_prod    = 64'($signed({1'b0, mu_ff})) * 64'(s1_ff.step);
      s2_in.num        = 64'(s1_ff.step) * 64'(s1_ff.s);
      s2_in.rp_prod    = 64'(ps) * 64'(fac);
   end

   // stage 3: finish plain and iRprop-, set up both dividers
   always_comb begin
      logic signed [63:0] x;
      logic signed [31:0] sn;
      logic signed [33:0] wn;
      logic signed [31:0] sp;
      logic               neg;
      logic signed [32:0] den;
      logic [63:0]        nabs;
      // plain step
      sp = sat32(s2_ff.plain_prod >>> FRAC_BITS);
      div0_in.step_plain = sp;
      div0_in.w_plain    = sat32(64'(s2_ff.w) + 64'(sp));
      // iRprop-
      x = s2_ff.rp_prod >>> FRAC_BITS;
      if (s2_ff.same) begin
         sn = (x > 64'(ceil_ff)) ? $signed({1'b0, ceil_ff}) : sat32(x);
      end else begin
         sn = (x < 64'(RPROP_STEP_MIN)) ? RPROP_STEP_MIN : sat32(x);
      end
      neg = s2_ff.same && s2_ff.slope[31];
      if (neg) begin
         wn = 34'(s2_ff.w) - 34'(sn);
         if (wn < 34'(wmin_ff)) wn = 34'(wmin_ff);
      end else begin
         wn = 34'(s2_ff.w) + 34'(sn);
         if (wn > 34'(wmax_ff)) wn = 34'(wmax_ff);
      end
      div0_in.step_rp = sn;
      div0_in.w_rp    = sat32(64'(wn));
      div0_in.prev_rp = s2_ff.same ? s2_ff.slope : 32'sd0;
      // QuickProp terms
      div0_in.w      = s2_ff.w;
      div0_in.step   = s2_ff.step;
      div0_in.prev   = s2_ff.prev;
      div0_in.s      = s2_ff.s;
      div0_in.lin    = QB'(s2_ff.lin_prod >>> FRAC_BITS);
      div0_in.mustep = QB'(s2_ff.mu_prod >>> FRAC_BITS);
      den  = 33'(s2_ff.prev) - 33'(s2_ff.s);
      nabs = s2_ff.num[63] ? 64'(-s2_ff.num) : 64'(s2_ff.num);
      div0_in.den_abs = den[32] ? 33'(-den) : 33'(den);
      div0_in.dz      = (den == 33'sd0);
      div0_in.q_neg   = s2_ff.num[63] ^ den[32];
      div0_in.ovf     = 33'(nabs[63:QB]) >= div0_in.den_abs;
      div0_in.r       = 33'(nabs[63:QB]);
      div0_in.num_lo  = nabs[QB-1:0];
      div0_in.q       = '0;
      // ratio mu / (1 + mu): quotient of (mu << FRAC_BITS) by (ONE + mu)
      div0_in.rr   = {1'b0, mu_ff};
      div0_in.rden = FX_ONE + {1'b0, mu_ff};
      div0_in.rq   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff    <= 1'b0;
         s2_v_ff    <= 1'b0;
         div_v_ff[0] <= 1'b0;
      end else if (en) begin
         s1_v_ff    <= req_tvalid;
         s2_v_ff    <= s1_v_ff;
         div_v_ff[0] <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff     <= s1_in;
         s2_ff     <= s2_in;
         div_ff[0] <= div0_in;
      end
   end

   // restoring divider: one quotient bit per stage
   for (genvar k = 0; k < QB; k++) begin : g_div
      div_type d_in;
      always_comb begin
         logic [33:0] r2;
         logic        ge;
         logic [32:0] rr2;
         logic        rge;
         d_in   = div_ff[k];
         r2     = {div_ff[k].r, div_ff[k].num_lo[QB-1]};
         ge     = r2 >= {1'b0, div_ff[k].den_abs};
         d_in.r = ge ? 33'(r2 - {1'b0, div_ff[k].den_abs}) : r2[32:0];
         d_in.q = {div_ff[k].q[QB-2:0], ge};
         d_in.num_lo = {div_ff[k].num_lo[QB-2:0], 1'b0};
         rr2 = {div_ff[k].rr, 1'b0};
         rge = rr2 >= {1'b0, div_ff[k].rden};
         if (k < RB) begin
            d_in.rr = rge ? 32'(rr2 - {1'b0, div_ff[k].rden}) : rr2[31:0];
            d_in.rq = {div_ff[k].rq[RB-2:0], rge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            div_v_ff[k+1] <= div_v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            div_ff[k+1] <= d_in;
         end
      end
   end

   // post 1: sign the quotient, scale prev by the ratio
   always_comb begin
      logic signed [63:0] cp;
      div_type d;
      d  = div_ff[QB];
      cp = (64'($signed({1'b0, d.rq})) * 64'(d.prev)) >>> FRAC_BITS;
      if (d.dz) begin
         p1_in.quad = '0;
      end else if (d.ovf) begin
         p1_in.quad = d.q_neg ? -(CW'(1) <<< QB) : (CW'(1) <<< QB);
      end else begin
         p1_in.quad = d.q_neg ? -CW'({2'b00, d.q}) : CW'({2'b00, d.q});
      end
      p1_in.cmp        = cp[31:0];
      p1_in.w          = d.w;
      p1_in.step       = d.step;
      p1_in.prev       = d.prev;
      p1_in.s          = d.s;
      p1_in.lin        = d.lin;
      p1_in.mustep     = d.mustep;
      p1_in.w_plain    = d.w_plain;
      p1_in.step_plain = d.step_plain;
      p1_in.w_rp       = d.w_rp;
      p1_in.step_rp    = d.step_rp;
      p1_in.prev_rp    = d.prev_rp;
   end

   // post 2: QuickProp change
   always_comb begin
      logic signed [CW-1:0] ch;
      logic signed [CW-1:0] lin;
      logic signed [CW-1:0] mus;
      lin = CW'(p1_ff.lin);
      mus = CW'(p1_ff.mustep);
      priority if (p1_ff.step > QP_MIN_STEP) begin
         ch = (p1_ff.s > 0) ? lin : '0;
         ch = ch + ((p1_ff.s > p1_ff.cmp) ? mus : p1_ff.quad);
      end else if (p1_ff.step < QP_MIN_STEP_NEG) begin
         ch = (p1_ff.s < 0) ? lin : '0;
         ch = ch + ((p1_ff.s < p1_ff.cmp) ? mus : p1_ff.quad);
      end else begin
         ch = lin;
      end
      p2_in.step_q     = sat32(64'(ch));
      p2_in.w          = p1_ff.w;
      p2_in.prev       = p1_ff.prev;
      p2_in.s          = p1_ff.s;
      p2_in.w_plain    = p1_ff.w_plain;
      p2_in.step_plain = p1_ff.step_plain;
      p2_in.w_rp       = p1_ff.w_rp;
      p2_in.step_rp    = p1_ff.step_rp;
      p2_in.prev_rp    = p1_ff.prev_rp;
   end

   // post 3: clamp the QuickProp weight, pick by mode
   always_comb begin
      logic signed [32:0] wsum;
      logic signed [32:0] wq;
      wsum = 33'(p2_ff.w) + 33'(p2_ff.step_q);
      priority if (wsum < 33'(wmin_ff)) begin
         wq = 33'(wmin_ff);
      end else if (wsum > 33'(wmax_ff)) begin
         wq = 33'(wmax_ff);
      end else begin
         wq = wsum;
      end
      unique case (mode_ff)
         MODE_RPROP: p3_in = {p2_ff.prev_rp, p2_ff.step_rp, p2_ff.w_rp};
         MODE_QPROP: p3_in = {p2_ff.s, p2_ff.step_q, wq[31:0]};
         default:    p3_in = {p2_ff.prev, p2_ff.step_plain, p2_ff.w_plain};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_v_ff <= 1'b0;
         p2_v_ff <= 1'b0;
         p3_v_ff <= 1'b0;
      end else if (en) begin
         p1_v_ff <= div_v_ff[QB];
         p2_v_ff <= p1_v_ff;
         p3_v_ff <= p2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
      end
   end

   // checks
   `BWU_ASSERT_SAME(a_stall_blocks_input, clock, reset, rsp_tvalid && !rsp_tready, !req_tready, "input taken while output stalled")
   `BWU_ASSERT_NEXT(a_valid_advances, clock, reset, en, p3_v_ff == $past(p2_v_ff), "valid bit lost in last stage")
   `BWU_ASSERT_SAME(a_rprop_step_nonneg, clock, reset, p2_v_ff, !p2_ff.step_rp[31], "negative iRprop step")

endmodule

// ===== bench/tb_batch_weight_update_rprop_quickprop.sv =====
// Self-checking bench for the batch weight update pipeline: predicts each beat in all three modes
module tb_batch_weight_update_rprop_quickprop;
   timeunit 1ns;
   timeprecision 1ps;

   import bwu_pkg::*;

   localparam int LATENCY   = 64;
   localparam int MAX_CYCLE = 400000;

   typedef struct packed {
      logic signed [31:0] slope;
      logic signed [31:0] prev;
      logic signed [31:0] step;
      logic signed [31:0] w;
   } upd_in_type;

   typedef struct packed {
      logic signed [31:0] prev;
      logic signed [31:0] step;
      logic signed [31:0] w;
   } upd_out_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;
   logic         csr_we;
   logic [2:0]   csr_addr;
   logic [31:0]  csr_wdata;

   // predictor copy of the registers
   logic [1:0]         cfg_mode;
   logic signed [63:0] cfg_rate, cfg_wmin, cfg_wmax;
   logic signed [63:0] cfg_grow, cfg_shrink, cfg_ceil, cfg_mu;

   upd_in_type  pending_q[$];
   upd_out_type expected_q[$];
   int       mismatches;
   int       cycle_count;
   int       hold_off;
   bit       held_once;
   bit       timed_out;

   batch_weight_update_rprop_quickprop u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic signed [63:0] clip32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   // product shifted down with floor rounding (arithmetic shift floors)
   function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
      logic signed [63:0] p;
      p = a * b;
      return p >>> FRAC_BITS;
   endfunction

   function automatic upd_out_type predict_update(input upd_in_type it);
      logic signed [63:0] w, step, prev, slope, ps, wn, sn, pn;
      logic signed [63:0] ratio, ch, s, den, quad;
      upd_out_type r;
      w = it.w; step = it.step; prev = it.prev; slope = it.slope;
      if (cfg_mode == MODE_RPROP) begin
         ps = (step < RPROP_STEP_FLOOR) ? 64'(RPROP_STEP_FLOOR) : step;
         if ((prev >= 0 && slope >= 0) || (prev <= 0 && slope <= 0)) begin
            sn = fx_mul(ps, cfg_grow);
            if (sn > cfg_ceil) sn = cfg_ceil;
         end else begin
            sn = fx_mul(ps, cfg_shrink);
            if (sn < RPROP_STEP_MIN) sn = RPROP_STEP_MIN;
            slope = 0;
         end
         sn = clip32(sn);
         if (slope < 0) begin
            wn = w - sn;
            if (wn < cfg_wmin) wn = cfg_wmin;
         end else begin
            wn = w + sn;
            if (wn > cfg_wmax) wn = cfg_wmax;
         end
         pn = slope;
      end else if (cfg_mode == MODE_QPROP) begin
         ratio = (cfg_mu * 64'sd65536) / (64'sd65536 + cfg_mu);
         ch = 0;
         s = clip32(slope + fx_mul(64'(QP_DECAY), w));
         den = prev - s;
         quad = (den != 0) ? (step * s) / den : 64'sd0;
         if (step > QP_MIN_STEP) begin
            if (s > 0) ch += fx_mul(cfg_rate, s);
            if (s > fx_mul(ratio, prev)) ch += fx_mul(cfg_mu, step);
            else ch += quad;
         end else if (step < -64'(QP_MIN_STEP)) begin
            if (s < 0) ch += fx_mul(cfg_rate, s);
            if (s < fx_mul(ratio, prev)) ch += fx_mul(cfg_mu, step);
            else ch += quad;
         end else begin
            ch = fx_mul(cfg_rate, s);
         end
         sn = clip32(ch);
         wn = w + sn;
         if (wn < cfg_wmin) wn = cfg_wmin;
         else if (wn > cfg_wmax) wn = cfg_wmax;
         pn = s;
      end else begin
         sn = clip32(fx_mul(slope, cfg_rate));
         wn = w + sn;
         pn = prev;
      end
      r.w = clip32(wn);
      r.step = clip32(sn);
      r.prev = clip32(pn);
      return r;
   endfunction

   function automatic logic [31:0] rand_field();
      case ($urandom_range(0, 7))
         0: return 32'h7FFFFFFF;
         1: return 32'h80000000;
         2: return 32'(0);
         3: return 32'($signed($urandom_range(0, 8)) - 4);
         4, 5: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   function automatic upd_in_type rand_item();
      upd_in_type it;
      it.w = rand_field(); it.step = rand_field();
      it.prev = rand_field(); it.slope = rand_field();
      return it;
   endfunction

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // driver: offer queued beats with random gaps
   int req_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_q.push_back(predict_update(upd_in_type'(req_tdata)));
            void'(pending_q.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            // hold the beat
         end else if (req_gap > 0 || pending_q.size() == 0 ||
                      (req_tvalid && req_tready && pending_q.size() == 0)) begin
            req_tvalid <= 1'b0;
            if (req_gap > 0) req_gap <= req_gap - 1;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_q[0];
            req_gap    <= gap_len();
         end
      end
   end

   // the head of pending_q is popped on acceptance, so re-offer from the next entry
   // (the driver reads pending_q[0] before the pop lands only when no beat is in flight)

   // monitor and stall control
   int rsp_gap;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_gap    <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected beat %h", rsp_tdata);
            end else begin
               upd_out_type e, a;
               e = expected_q.pop_front();
               a = upd_out_type'(rsp_tdata);
               if (a.w !== e.w || a.step !== e.step || a.prev !== e.prev) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch mode %0d: exp w %h step %h prev %h, got %h %h %h",
                              cfg_mode, e.w, e.step, e.prev, a.w, a.step, a.prev);
               end
            end
         end
         if (hold_off > 0) begin
            rsp_tready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_tready <= 1'b0;
            rsp_gap <= rsp_gap - 1;
         end else begin
            rsp_tready <= 1'b1;
            rsp_gap <= ($urandom_range(0, 3) == 0) ? gap_len() : 0;
         end
      end
   end

   // long receiver hold-off once plenty of beats wait to be sent
   always @(posedge clock) begin
      if (reset) begin
         hold_off  <= 0;
         held_once <= 1'b0;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
      end else if (!held_once && pending_q.size() >= 60) begin
         hold_off  <= 600;
         held_once <= 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset) begin
         cycle_count <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count >= MAX_CYCLE && !timed_out) begin
            timed_out = 1'b1;
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // raise the write for one edge; the caller drops csr_we after the last one
   task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         REG_MODE:       cfg_mode = val[1:0];
         REG_BATCH_RATE: cfg_rate = $signed(val);
         REG_WEIGHT_MIN: cfg_wmin = $signed(val);
         REG_WEIGHT_MAX: cfg_wmax = $signed(val);
         REG_GROW:       cfg_grow = {33'd0, val[30:0]};
         REG_SHRINK:     cfg_shrink = {33'd0, val[30:0]};
         REG_CEILING:    cfg_ceil = {33'd0, val[30:0]};
         REG_QP_MU:      cfg_mu = {33'd0, val[30:0]};
         default: ;
      endcase
   endtask

   // drain the pipeline before touching registers
   task automatic wait_idle();
      while (pending_q.size() != 0 || req_tvalid || expected_q.size() != 0)
         @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   task automatic push_random(input int n);
      for (int i = 0; i < n; i++) pending_q.push_back(rand_item());
   endtask

   task automatic push_directed();
      upd_in_type it;
      logic [31:0] ext[4];
      ext = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'hFFFFFFFF};
      for (int i = 0; i < 4; i++) begin
         it.w = ext[i]; it.step = ext[(i + 1) % 4];
         it.prev = ext[(i + 2) % 4]; it.slope = ext[(i + 3) % 4];
         pending_q.push_back(it);
      end
      // zero divisor: prev equals slope
      it.w = 32'h10000; it.step = 32'h8000; it.prev = 32'h20000; it.slope = 32'h20000;
      pending_q.push_back(it);
      // opposite slope signs
      it.prev = 32'hFFFE0000; it.slope = 32'h30000;
      pending_q.push_back(it);
      it.step = 32'hFFFF8000; it.prev = 32'h30000; it.slope = 32'hFFFD0000;
      pending_q.push_back(it);
   endtask

   initial begin
      logic [31:0] vals[8];
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_addr   = REG_MODE;
      csr_wdata  = '0;
      cfg_mode = MODE_PLAIN; cfg_rate = 0; cfg_wmin = 0; cfg_wmax = 0;
      cfg_grow = GROW_RESET; cfg_shrink = SHRINK_RESET;
      cfg_ceil = CEILING_RESET; cfg_mu = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults first, then a run of settings with the extremes
      push_directed();
      push_random(20);
      wait_idle();
      for (int ph = 0; ph < 12; ph++) begin
         vals[REG_MODE] = (ph == 11) ? 32'd3 : 32'(ph % 3);
         case (ph % 4)
            0: vals[REG_BATCH_RATE] = 32'h7FFFFFFF;
            1: vals[REG_BATCH_RATE] = 32'h80000000;
            default: vals[REG_BATCH_RATE] = rand_field();
         endcase
         if (ph == 2) begin
            vals[REG_WEIGHT_MIN] = 32'h80000000; vals[REG_WEIGHT_MAX] = 32'h7FFFFFFF;
         end else if (ph == 5) begin
            vals[REG_WEIGHT_MIN] = 32'h00100000; vals[REG_WEIGHT_MAX] = 32'hFFF00000;
         end else begin
            vals[REG_WEIGHT_MIN] = -$signed($urandom_range(0, 1 << 24));
            vals[REG_WEIGHT_MAX] = $urandom_range(0, 1 << 24);
         end
         vals[REG_GROW]    = (ph == 4) ? 32'h7FFFFFFF : $urandom_range(0, 1 << 18);
         vals[REG_SHRINK]  = (ph == 7) ? 32'h7FFFFFFF : $urandom_range(0, 1 << 17);
         vals[REG_CEILING] = (ph == 1) ? 32'h7FFFFFFF : $urandom;
         vals[REG_QP_MU]   = (ph == 8) ? 32'h7FFFFFFF :
                             (ph == 5) ? 32'h0 : $urandom_range(0, 1 << 19);
         for (int r = 0; r < 8; r++) write_reg(3'(r), vals[r]);
         csr_we <= 1'b0;
         if (ph % 3 == 0) push_directed();
         push_random(75);
         wait_idle();
      end
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
